>>> design/s2a_pkg.sv
// shared types, constants and key tables for the scancode to ascii block
`default_nettype none
package s2a_pkg;

  localparam int FIFO_DEPTH = 64;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int CHAR_W     = 7;
  localparam int FILL_W     = 7;
  localparam int TAB_SIZE   = 58;

  typedef enum logic {
    OP_SCANCODE = 1'b0,
    OP_READ     = 1'b1
  } op_t;

  typedef struct packed {
    op_t        operation;
    logic [7:0] scancode;
  } in_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0] read_char;
    logic              char_valid;
    logic [FILL_W-1:0] fill_level;
  } out_word_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [CHAR_W-1:0] wdata;
  } fifo_ctl_t;

  typedef struct packed {
    logic             empty;
    logic             full;
    logic [CNT_W-1:0] level;
  } fifo_stat_t;

  // set-1 key codes, release flag stripped
  localparam logic [6:0] KEY_ESC    = 7'h01;
  localparam logic [6:0] KEY_BKSP   = 7'h0E;
  localparam logic [6:0] KEY_ENTER  = 7'h1C;
  localparam logic [6:0] KEY_CTRL   = 7'h1D;
  localparam logic [6:0] KEY_LSHIFT = 7'h2A;
  localparam logic [6:0] KEY_X      = 7'h2D;
  localparam logic [6:0] KEY_C      = 7'h2E;
  localparam logic [6:0] KEY_RSHIFT = 7'h36;
  localparam logic [6:0] KEY_SPACE  = 7'h39;

  localparam logic [CHAR_W-1:0] CH_NONE  = 7'h00;
  localparam logic [CHAR_W-1:0] CH_ETX   = 7'h03;
  localparam logic [CHAR_W-1:0] CH_BS    = 7'h08;
  localparam logic [CHAR_W-1:0] CH_LF    = 7'h0A;
  localparam logic [CHAR_W-1:0] CH_CAN   = 7'h18;
  localparam logic [CHAR_W-1:0] CH_ESC   = 7'h1B;
  localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;

  localparam logic [CHAR_W-1:0] PLAIN_TAB [TAB_SIZE] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h00, 7'h00,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h00, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B,
    7'h6C, 7'h3B, 7'h27, 7'h60, 7'h00,
    7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D,
    7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  localparam logic [CHAR_W-1:0] SHIFT_TAB [TAB_SIZE] = '{
    7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h00, 7'h00,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h00, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B,
    7'h4C, 7'h3A, 7'h22, 7'h7E, 7'h00,
    7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D,
    7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

endpackage
`default_nettype wire

>>> design/s2a_keymap.sv
// scancode decoder with ctrl and shift tracking
`default_nettype none
module s2a_keymap
  import s2a_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              key_en,
  input  wire logic [7:0]        code,
  output logic      [CHAR_W-1:0] key_char
);

  logic       ctrl_r, ctrl_nxt;
  logic       shift_r, shift_nxt;
  logic       release_key;
  logic [6:0] key;

  assign release_key = code[7];
  assign key         = code[6:0];

  always_comb begin
    ctrl_nxt  = ctrl_r;
    shift_nxt = shift_r;
    key_char  = CH_NONE;
    if (release_key) begin
      if (key == KEY_CTRL) ctrl_nxt = 1'b0;
      if (key == KEY_LSHIFT || key == KEY_RSHIFT) shift_nxt = 1'b0;
    end else begin
      priority if (key == KEY_CTRL) begin
        ctrl_nxt = 1'b1;
      end else if (key == KEY_LSHIFT || key == KEY_RSHIFT) begin
        shift_nxt = 1'b1;
      end else if (key == KEY_ESC) begin
        key_char = CH_ESC;
      end else if (key == KEY_ENTER) begin
        key_char = CH_LF;
      end else if (key == KEY_BKSP) begin
        key_char = CH_BS;
      end else if (key == KEY_SPACE) begin
        key_char = CH_SPACE;
      end else if (ctrl_r && key == KEY_C) begin
        key_char = CH_ETX;
      end else if (ctrl_r && key == KEY_X) begin
        key_char = CH_CAN;
      end else if (key < 7'(TAB_SIZE)) begin
        key_char = shift_r ? SHIFT_TAB[key[5:0]] : PLAIN_TAB[key[5:0]];
      end else begin
        key_char = CH_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r  <= 1'b0;
      shift_r <= 1'b0;
    end else if (key_en) begin
      ctrl_r  <= ctrl_nxt;
      shift_r <= shift_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/s2a_fifo.sv
// character fifo: storage array, pointers and fill count
`default_nettype none
module s2a_fifo
  import s2a_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire fifo_ctl_t         ctl,
  output fifo_stat_t             stat,
  output logic      [CHAR_W-1:0] rd_data_r
);

  logic [CHAR_W-1:0] mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_W'(FIFO_DEPTH));
  assign stat.level = count_r;

  always_comb begin
    wr_ptr_nxt = ctl.push ? next_slot(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = ctl.pop  ? next_slot(rd_ptr_r) : rd_ptr_r;
    unique case ({ctl.push, ctl.pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // push and pop never hit the same slot: that needs an empty or full fifo
  always_ff @(posedge clk) begin
    if (ctl.push) mem[wr_ptr_r] <= ctl.wdata;
    if (ctl.pop)  rd_data_r     <= mem[rd_ptr_r];
  end

endmodule
`default_nettype wire

>>> design/scancode_to_ascii_fifo.sv
// top level: input register, key decoder, character fifo and result register
//
// Takes one word per clock unless stalled: either a set-1 scancode, decoded
// with ctrl and shift tracking and pushed into a 64-entry character fifo
// (dropped when full or when the key gives no character), or a host read
// that pops one character. Every read gives one result word, with
// char_valid low and all fields zero when the fifo is empty; scancodes give
// none. A word is held in the input register and is decoded and applied to
// the fifo when it advances out of it, and a read result is then held in the
// result register until taken. One word per cycle is sustained; only a
// stalled result holds up a following read, since the single result
// register must drain before the next one is loaded.
`default_nettype none
module scancode_to_ascii_fifo
  import s2a_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_data
);

  logic              in_valid_r, in_valid_nxt;
  in_word_t          in_word_r;
  logic              in_take;
  logic              advance;
  logic              is_read;
  logic              out_valid_r, out_valid_nxt;
  logic              char_valid_r;
  logic [FILL_W-1:0] fill_level_r;
  logic [FILL_W-1:0] fill_after;
  logic [CNT_W-1:0]  level_left;
  logic [CHAR_W-1:0] key_char;
  logic [CHAR_W-1:0] rd_data;
  fifo_ctl_t         fifo_ctl;
  fifo_stat_t        fifo_stat;

  assign is_read  = (in_word_r.operation == OP_READ);
  // a scancode never needs the result register
  assign advance  = in_valid_r && (!is_read || !out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign in_valid_nxt = in_take || (in_valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) in_word_r <= in_data;
  end

  s2a_keymap u_keymap (
    .clk      (clk),
    .rst_n    (rst_n),
    .key_en   (advance && !is_read),
    .code     (in_word_r.scancode),
    .key_char (key_char)
  );

  assign fifo_ctl.push  = advance && !is_read && (key_char != CH_NONE) && !fifo_stat.full;
  assign fifo_ctl.pop   = advance && is_read && !fifo_stat.empty;
  assign fifo_ctl.wdata = key_char;

  s2a_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (fifo_ctl),
    .stat      (fifo_stat),
    .rd_data_r (rd_data)
  );

  assign level_left = fifo_stat.level - CNT_W'(1);
  assign fill_after = fifo_stat.empty ? '0 : FILL_W'(level_left);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && is_read) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_read) begin
      char_valid_r <= !fifo_stat.empty;
      fill_level_r <= fill_after;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_data.read_char  = char_valid_r ? rd_data : CH_NONE;
  assign out_data.char_valid = char_valid_r;
  assign out_data.fill_level = fill_level_r;

endmodule
`default_nettype wire
